// ===== rtl/ps2m_pkg.sv =====
// shared types, constants and codes for the ps2 mouse packet decoder
package ps2m_pkg;

    localparam int REG_W         = 12;
    localparam int BYTE_W        = 8;
    localparam int BTN_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = 12'd320;
    localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = 12'd200;

    localparam logic [BYTE_W-1:0] ACK_BYTE  = 8'hFA;
    localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hC8;
    localparam logic [BYTE_W-1:0] HDR_MATCH = 8'h08;

    localparam int XSIGN_POS = 4;
    localparam int YSIGN_POS = 5;

    typedef enum logic
    {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        PH_WAIT_ACK = 2'd0,
        PH_HEADER   = 2'd1,
        PH_XBYTE    = 2'd2,
        PH_YBYTE    = 2'd3
    } phase_t;

    typedef struct packed
    {
        logic              operation;
        logic [BYTE_W-1:0] data_byte;
    } byte_req_t;

    typedef struct packed
    {
        logic [REG_W-1:0] pos_x;
        logic [REG_W-1:0] pos_y;
        logic [BTN_W-1:0] buttons;
    } pos_req_t;

    typedef struct packed
    {
        logic [REG_W-1:0] screen_width;
        logic [REG_W-1:0] screen_height;
    } screen_cfg_t;

endpackage

// ===== rtl/ps2m_cfg.sv =====
// screen size configuration registers
module ps2m_cfg
    import ps2m_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    output screen_cfg_t          screen
);

    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SCREEN_WIDTH)
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_SCREEN_HEIGHT)
            begin
                height_reg <= cfg_wdata;
            end
        end
    end

    assign screen.screen_width  = width_reg;
    assign screen.screen_height = height_reg;

endmodule

// ===== rtl/ps2m_in_stage.sv =====
// input register stage for received byte requests
module ps2m_in_stage
    import ps2m_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  byte_req_t byte_req,
    input  logic      advance,
    output logic      held_valid,
    output byte_req_t held_req
);

    logic      valid_reg;
    logic      valid_next;
    byte_req_t req_reg;

    assign byte_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_valid && byte_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            req_reg <= byte_req;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = req_reg;

endmodule

// ===== rtl/ps2m_track.sv =====
// packet framing, position update with clamping, and result register
module ps2m_track
    import ps2m_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  screen_cfg_t screen,
    input  logic        held_valid,
    input  byte_req_t   held_req,
    output logic        advance,
    output logic        pos_valid,
    input  logic        pos_ready,
    output pos_req_t    pos_req
);

    localparam int CMP_W = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 2;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int HALF_W = int'(SCREEN_WIDTH_RST) / 2;
    localparam int HALF_H = int'(SCREEN_HEIGHT_RST) / 2;
    localparam logic [COORD_BITS-1:0] CUR_X_RST =
        COORD_BITS'((HALF_W > COORD_MAX) ? COORD_MAX : HALF_W);
    localparam logic [COORD_BITS-1:0] CUR_Y_RST =
        COORD_BITS'((HALF_H > COORD_MAX) ? COORD_MAX : HALF_H);
    localparam logic [CMP_W-1:0] COORD_MAX_EXT = CMP_W'(COORD_MAX);

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [BYTE_W-1:0]       header_reg;
    logic [BYTE_W-1:0]       header_next;
    logic [BYTE_W-1:0]       xbyte_reg;
    logic [BYTE_W-1:0]       xbyte_next;
    logic [COORD_BITS-1:0]   cur_x_reg;
    logic [COORD_BITS-1:0]   cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg;
    logic [COORD_BITS-1:0]   cur_y_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    pos_req_t                out_reg;
    pos_req_t                out_next;

    logic                    fire;
    logic                    emit;
    logic [COORD_BITS-1:0]   hi_x;
    logic [COORD_BITS-1:0]   hi_y;
    logic signed [BYTE_W:0]  dx;
    logic signed [BYTE_W:0]  dy;
    logic signed [CMP_W-1:0] sum_x;
    logic signed [CMP_W-1:0] sum_y;
    logic [COORD_BITS-1:0]   new_x;
    logic [COORD_BITS-1:0]   new_y;
    logic [COORD_BITS-1:0]   centre_x;
    logic [COORD_BITS-1:0]   centre_y;

    function automatic logic [COORD_BITS-1:0] upper_limit(input logic [REG_W-1:0] lim);
        logic [CMP_W-1:0] lim_ext;
        lim_ext = CMP_W'(lim);
        if (lim_ext > COORD_MAX_EXT)
        begin
            return COORD_BITS'(COORD_MAX);
        end
        return COORD_BITS'(lim);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [CMP_W-1:0] v,
                                                    input logic [COORD_BITS-1:0] hi);
        logic [CMP_W-1:0] hi_ext;
        hi_ext = CMP_W'(hi);
        if (v[CMP_W-1])
        begin
            return '0;
        end
        if (unsigned'(v) > hi_ext)
        begin
            return hi;
        end
        return v[COORD_BITS-1:0];
    endfunction

    assign advance = !out_valid_reg || pos_ready;
    assign fire    = held_valid && advance;

    assign hi_x = upper_limit(screen.screen_width);
    assign hi_y = upper_limit(screen.screen_height);

    assign dx = {header_reg[XSIGN_POS], xbyte_reg};
    assign dy = {header_reg[YSIGN_POS], held_req.data_byte};

    assign sum_x = signed'({{(CMP_W-COORD_BITS){1'b0}}, cur_x_reg})
                 + {{(CMP_W-BYTE_W-1){dx[BYTE_W]}}, dx};
    assign sum_y = signed'({{(CMP_W-COORD_BITS){1'b0}}, cur_y_reg})
                 - {{(CMP_W-BYTE_W-1){dy[BYTE_W]}}, dy};

    assign new_x = clamp(sum_x, hi_x);
    assign new_y = clamp(sum_y, hi_y);

    assign centre_x = clamp(signed'(CMP_W'(screen.screen_width >> 1)), hi_x);
    assign centre_y = clamp(signed'(CMP_W'(screen.screen_height >> 1)), hi_y);

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xbyte_next  = xbyte_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        emit        = 1'b0;
        if (fire)
        begin
            if (held_req.operation == OP_RESTART)
            begin
                phase_next = PH_WAIT_ACK;
                cur_x_next = centre_x;
                cur_y_next = centre_y;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT_ACK:
                    begin
                        if (held_req.data_byte == ACK_BYTE)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        if ((held_req.data_byte & HDR_MASK) == HDR_MATCH)
                        begin
                            header_next = held_req.data_byte;
                            phase_next  = PH_XBYTE;
                        end
                    end
                    PH_XBYTE:
                    begin
                        xbyte_next = held_req.data_byte;
                        phase_next = PH_YBYTE;
                    end
                    PH_YBYTE:
                    begin
                        cur_x_next = new_x;
                        cur_y_next = new_y;
                        phase_next = PH_HEADER;
                        emit       = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_WAIT_ACK;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_next.pos_x   = REG_W'(new_x);
            out_next.pos_y   = REG_W'(new_y);
            out_next.buttons = header_reg[BTN_W-1:0];
        end
        else if (pos_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_ACK;
            header_reg    <= '0;
            xbyte_reg     <= '0;
            cur_x_reg     <= CUR_X_RST;
            cur_y_reg     <= CUR_Y_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            header_reg    <= header_next;
            xbyte_reg     <= xbyte_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign pos_valid = out_valid_reg;
    assign pos_req   = out_reg;

endmodule

// ===== rtl/ps2_mouse_packet_decoder.sv =====
// top level of the ps2 mouse three-byte packet decoder
// a position request is written to the result register once the third packet byte leaves the input register
// throughput: one byte request per cycle; input stalls only while a result waits
// the path is one input register and one result register around the update logic
// reset: async active low; waits for acknowledge, position centred at 160/100
// screen registers reset to 320 and 200
module ps2_mouse_packet_decoder
    import ps2m_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  byte_req_t            byte_req,
    output logic                 pos_valid,
    input  logic                 pos_ready,
    output pos_req_t             pos_req,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata
);

    screen_cfg_t screen;
    logic        advance;
    logic        held_valid;
    byte_req_t   held_req;

    ps2m_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .screen    (screen)
    );

    ps2m_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_req   (byte_req),
        .advance    (advance),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    ps2m_track #(
        .COORD_BITS (COORD_BITS)
    ) u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .screen     (screen),
        .held_valid (held_valid),
        .held_req   (held_req),
        .advance    (advance),
        .pos_valid  (pos_valid),
        .pos_ready  (pos_ready),
        .pos_req    (pos_req)
    );

endmodule

// ===== rtl/ps2m_checker.sv =====
// port-level checker for the ps2 mouse packet decoder, with its bind
module ps2m_checker
    import ps2m_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_ready,
    input byte_req_t byte_req,
    input logic      pos_valid,
    input logic      pos_ready,
    input pos_req_t  pos_req
);

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && !pos_ready |=> pos_valid && $stable(pos_req))
        else $error("position request dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> pos_valid && !pos_ready)
        else $error("byte input stalled without output backpressure");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pos_valid) |-> $past(byte_valid && byte_ready
                                   && byte_req.operation == OP_BYTE, 2))
        else $error("result without a byte request two cycles earlier");

    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_req.operation == OP_RESTART
            |=> ##1 !$rose(pos_valid))
        else $error("restart produced a result");

endmodule

bind ps2_mouse_packet_decoder ps2m_checker u_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_req   (byte_req),
    .pos_valid  (pos_valid),
    .pos_ready  (pos_ready),
    .pos_req    (pos_req)
);
